>>> rtl/bcd_pkg.sv
// Shared types and constants for the button click event detector.
`timescale 1ns / 1ps

package bcd_pkg;

   // Field and counter widths.
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned REPEAT_W    = 4;
   localparam int unsigned DEB_W       = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned LAST_W      = 4;

   // Saturation points of the hold tick counter and of the repeat counter.
   localparam logic [TICK_W-1:0]   TICK_SATURATE = 16'd65530;
   localparam logic [REPEAT_W-1:0] REPEAT_MAX    = 4'd15;

   // Register values after reset.
   localparam logic              ACTIVE_LEVEL_RESET   = 1'b0;
   localparam logic [DEB_W-1:0]  DEBOUNCE_LIMIT_RESET = 8'd3;
   localparam logic [TICK_W-1:0] SHORT_LIMIT_RESET    = 16'd60;
   localparam logic [TICK_W-1:0] LONG_LIMIT_RESET     = 16'd200;
   localparam logic [TICK_W-1:0] IDLE_LIMIT_RESET     = 16'd2000;

   // Events reported on each word.
   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_DOWN       = 3'd1,
      EV_UP         = 3'd2,
      EV_REPEAT     = 3'd3,
      EV_SINGLE     = 3'd4,
      EV_DOUBLE     = 3'd5,
      EV_LONG_START = 3'd6,
      EV_LONG_HOLD  = 3'd7
   } event_type;

   // Extra code of the stored event register.
   localparam logic [LAST_W-1:0] EV_IDLE_TIMEOUT = 4'd8;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_LEVEL   = 3'd0,
      CSR_DEBOUNCE_LIMIT = 3'd1,
      CSR_SHORT_LIMIT    = 3'd2,
      CSR_LONG_LIMIT     = 3'd3,
      CSR_IDLE_LIMIT     = 3'd4
   } csr_index_type;

   // Click state machine, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_PRESSED   = 5'b00010,
      ST_RELEASED  = 5'b00100,
      ST_REPEAT    = 5'b01000,
      ST_LONG_HOLD = 5'b10000
   } state_type;

   // Result of one tick, passed from the state machine to the output register.
   typedef struct packed {
      event_type         fired;
      logic              timeout;
      logic [LAST_W-1:0] last;
   } result_type;

endpackage

>>> rtl/bcd_debounce.sv
// Counter-based debouncer of the raw pin level.
`timescale 1ns / 1ps

module bcd_debounce (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     pin_raw,
   input  logic                     press_level,
   input  logic [bcd_pkg::DEB_W-1:0] debounce_limit,
   output logic                     pressed
);
   import bcd_pkg::*;

   logic             stable_ff;
   logic             stable_in;
   logic [DEB_W-1:0] count_ff;
   logic [DEB_W-1:0] count_in;
   logic [DEB_W-1:0] count_inc;

   // A differing level is taken once it has persisted for the limit in ticks.
   always_comb begin
      count_inc = count_ff + 8'd1;
      stable_in = stable_ff;
      count_in  = '0;
      if (pin_raw != stable_ff) begin
         if (count_inc >= debounce_limit) begin
            stable_in = pin_raw;
            count_in  = '0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   // The state machine sees the level as updated by this word.
   assign pressed = (stable_in == press_level);

   // Debounce state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= ~ACTIVE_LEVEL_RESET;
         count_ff  <= '0;
      end else if (accept) begin
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/bcd_fsm.sv
// Click state machine with hold, release and repeat counters.
`timescale 1ns / 1ps

module bcd_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      pressed,
   input  logic [bcd_pkg::TICK_W-1:0] short_limit,
   input  logic [bcd_pkg::TICK_W-1:0] long_limit,
   input  logic [bcd_pkg::TICK_W-1:0] idle_limit,
   output bcd_pkg::result_type       result
);
   import bcd_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   logic [TICK_W-1:0]   hold_ff;
   logic [TICK_W-1:0]   hold_in;
   logic [TICK_W-1:0]   hold_mid;
   logic [TICK_W-1:0]   release_ff;
   logic [TICK_W-1:0]   release_in;
   logic [TICK_W-1:0]   release_inc;
   logic [REPEAT_W-1:0] repeat_ff;
   logic [REPEAT_W-1:0] repeat_in;
   logic [LAST_W-1:0]   event_ff;
   logic [LAST_W-1:0]   event_in;
   event_type           fired;
   logic                timeout;

   always_comb begin
      state_in    = state_ff;
      repeat_in   = repeat_ff;
      fired       = EV_NONE;
      timeout     = 1'b0;
      release_inc = release_ff + 16'd1;

      // Tick counting: hold time outside idle, release time in idle.
      if (state_ff != ST_IDLE) begin
         hold_mid   = (hold_ff < TICK_SATURATE) ? hold_ff + 16'd1 : hold_ff;
         release_in = '0;
      end else begin
         hold_mid = hold_ff;
         if (release_inc > idle_limit) begin
            timeout    = 1'b1;
            release_in = '0;
         end else begin
            release_in = release_inc;
         end
      end
      hold_in = hold_mid;

      // State transitions and the event fired by each.
      unique case (state_ff)
         ST_IDLE: begin
            if (pressed) begin
               fired     = EV_DOWN;
               hold_in   = '0;
               repeat_in = 4'd1;
               state_in  = ST_PRESSED;
            end
         end
         ST_PRESSED: begin
            if (!pressed) begin
               fired    = EV_UP;
               hold_in  = '0;
               state_in = ST_RELEASED;
            end else if (hold_mid > long_limit) begin
               fired    = EV_LONG_START;
               state_in = ST_LONG_HOLD;
            end
         end
         ST_RELEASED: begin
            if (pressed) begin
               if (repeat_ff < REPEAT_MAX) begin
                  repeat_in = repeat_ff + 4'd1;
               end
               fired    = EV_REPEAT;
               hold_in  = '0;
               state_in = ST_REPEAT;
            end else if (hold_mid > short_limit) begin
               if (repeat_ff == 4'd1) begin
                  fired = EV_SINGLE;
               end else if (repeat_ff == 4'd2) begin
                  fired = EV_DOUBLE;
               end
               state_in = ST_IDLE;
            end
         end
         ST_REPEAT: begin
            if (!pressed) begin
               fired = EV_UP;
               if (hold_mid < short_limit) begin
                  hold_in  = '0;
                  state_in = ST_RELEASED;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LONG_HOLD: begin
            if (pressed) begin
               fired = EV_LONG_HOLD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
         end
      endcase

      // In idle the stored event always follows the fired event, which also
      // hides the timeout code; elsewhere only a real event replaces it.
      if (state_ff == ST_IDLE || fired != EV_NONE) begin
         event_in = {1'b0, fired};
      end else begin
         event_in = event_ff;
      end
   end

   assign result.fired   = fired;
   assign result.timeout = timeout;
   assign result.last    = event_in;

   // Machine state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         hold_ff    <= '0;
         release_ff <= '0;
         repeat_ff  <= '0;
         event_ff   <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         hold_ff    <= hold_in;
         release_ff <= release_in;
         repeat_ff  <= repeat_in;
         event_ff   <= event_in;
      end
   end

endmodule

>>> rtl/button_click_event_detector.sv
// Top level of the button click event detector: registers, datapath and output stage.
`timescale 1ns / 1ps

// Each accepted word is one tick carrying the raw pin level; the block
// debounces it, runs the click state machine and returns exactly one result
// word per tick (fired event, idle timeout flag, stored last event), held in a
// single output register loaded on acceptance. A new word is accepted whenever
// that register is empty or is being drained in the same cycle, so the rate is
// one word per cycle while the receiver does not stall. The user must write
// configuration registers through the csr_ port only while no result is
// outstanding; the block itself does not enforce it. Writing the press level
// register does not move the debounced level, which settles to the pin within
// debounce_limit ticks.
module button_click_event_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_pin,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_fired_event,
   output logic                           rsp_idle_timeout,
   output logic [bcd_pkg::LAST_W-1:0]     rsp_last_event,
   input  logic                           csr_write,
   input  logic [bcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bcd_pkg::*;

   logic              press_level_ff;
   logic [DEB_W-1:0]  debounce_limit_ff;
   logic [TICK_W-1:0] short_limit_ff;
   logic [TICK_W-1:0] long_limit_ff;
   logic [TICK_W-1:0] idle_limit_ff;

   logic              accept;
   logic              pressed;
   result_type        result;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_word_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         press_level_ff    <= ACTIVE_LEVEL_RESET;
         debounce_limit_ff <= DEBOUNCE_LIMIT_RESET;
         short_limit_ff    <= SHORT_LIMIT_RESET;
         long_limit_ff     <= LONG_LIMIT_RESET;
         idle_limit_ff     <= IDLE_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL:   press_level_ff    <= csr_wdata[0];
            CSR_DEBOUNCE_LIMIT: debounce_limit_ff <= csr_wdata[DEB_W-1:0];
            CSR_SHORT_LIMIT:    short_limit_ff    <= csr_wdata[TICK_W-1:0];
            CSR_LONG_LIMIT:     long_limit_ff     <= csr_wdata[TICK_W-1:0];
            CSR_IDLE_LIMIT:     idle_limit_ff     <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input handshake: stall only while a result waits and is not being taken.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   bcd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .pin_raw        (req_pin),
      .press_level    (press_level_ff),
      .debounce_limit (debounce_limit_ff),
      .pressed        (pressed)
   );

   bcd_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pressed     (pressed),
      .short_limit (short_limit_ff),
      .long_limit  (long_limit_ff),
      .idle_limit  (idle_limit_ff),
      .result      (result)
   );

   // Output register: loaded by every accepted word, held while stalled.
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired_event  = rsp_word_ff.fired;
   assign rsp_idle_timeout = rsp_word_ff.timeout;
   assign rsp_last_event   = rsp_word_ff.last;

`ifndef NO_ASSERTIONS
   // Every accepted word leaves a result waiting in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // A timeout only happens in idle, which fires nothing or a press.
   a_timeout_from_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.timeout) |->
         (rsp_word_ff.fired == EV_NONE || rsp_word_ff.fired == EV_DOWN))
      else $error("idle timeout reported outside idle");

   // A fired event is always the stored event of the same word.
   a_fired_is_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.fired != EV_NONE) |->
         (rsp_word_ff.last == {1'b0, rsp_word_ff.fired}))
      else $error("stored event differs from fired event");

   // The idle write of the stored event always hides the timeout code.
   a_no_timeout_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.last != EV_IDLE_TIMEOUT))
      else $error("timeout code escaped into a result");
`endif

endmodule

>>> test/tb_button_click_event_detector.sv
// Self-checking testbench for the button click event detector.
`timescale 1ns / 1ps

module tb_button_click_event_detector;
   import bcd_pkg::*;

   // First register index past the defined list; writes there must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   // Directed tick sequence, sent from the left: long press with long hold,
   // idle timeout, a double click and a triple click.
   localparam logic [24:0] CLICK_SCRIPT = 25'b1111100101000001010100000;

   // Tracks the block's registers and state, and queues one expected word per tick.
   class click_scoreboard;
      logic                act_level;
      logic [DEB_W-1:0]    deb_lim;
      logic [TICK_W-1:0]   short_lim;
      logic [TICK_W-1:0]   long_lim;
      logic [TICK_W-1:0]   idle_lim;
      state_type           st;
      logic [TICK_W-1:0]   hold_cnt;
      logic [TICK_W-1:0]   rel_cnt;
      logic [REPEAT_W-1:0] clicks;
      logic [DEB_W-1:0]    deb_cnt;
      logic                level;
      logic [LAST_W-1:0]   last_ev;
      result_type          awaited[$];
      int unsigned         failures;

      function new();
         act_level = ACTIVE_LEVEL_RESET;
         deb_lim   = DEBOUNCE_LIMIT_RESET;
         short_lim = SHORT_LIMIT_RESET;
         long_lim  = LONG_LIMIT_RESET;
         idle_lim  = IDLE_LIMIT_RESET;
         st        = ST_IDLE;
         hold_cnt  = '0;
         rel_cnt   = '0;
         clicks    = '0;
         deb_cnt   = '0;
         level     = ~ACTIVE_LEVEL_RESET;
         last_ev   = '0;
         failures  = 0;
      endfunction

      // Register write; indexes past the list change nothing.
      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ACTIVE_LEVEL:   act_level = val[0];
            CSR_DEBOUNCE_LIMIT: deb_lim   = val[DEB_W-1:0];
            CSR_SHORT_LIMIT:    short_lim = val;
            CSR_LONG_LIMIT:     long_lim  = val;
            CSR_IDLE_LIMIT:     idle_lim  = val;
            default: ;
         endcase
      endfunction

      // Advance by one accepted tick and queue the word it must produce.
      function void note_tick(logic pin);
         event_type  fired;
         logic       tmo;
         logic       pressed;
         result_type word;
         fired = EV_NONE;
         tmo   = 1'b0;

         // Hold ticks run outside idle; release ticks run in idle and time out.
         if (st != ST_IDLE) begin
            if (hold_cnt < TICK_SATURATE) hold_cnt++;
            rel_cnt = '0;
         end else begin
            rel_cnt = rel_cnt + 16'd1;
            if (rel_cnt > idle_lim) begin
               last_ev = EV_IDLE_TIMEOUT;
               tmo     = 1'b1;
               rel_cnt = '0;
            end
         end

         // Debounce: a new level is taken after enough differing ticks in a row.
         if (pin != level) begin
            deb_cnt = deb_cnt + 8'd1;
            if (deb_cnt >= deb_lim) begin
               level   = pin;
               deb_cnt = '0;
            end
         end else begin
            deb_cnt = '0;
         end
         pressed = (level == act_level);

         // Click state machine.
         case (st)
            ST_IDLE: begin
               if (pressed) begin
                  fired    = EV_DOWN;
                  hold_cnt = '0;
                  clicks   = 4'd1;
                  st       = ST_PRESSED;
               end
               last_ev = {1'b0, fired};
            end
            ST_PRESSED: begin
               if (!pressed) begin
                  fired    = EV_UP;
                  hold_cnt = '0;
                  st       = ST_RELEASED;
               end else if (hold_cnt > long_lim) begin
                  fired = EV_LONG_START;
                  st    = ST_LONG_HOLD;
               end
            end
            ST_RELEASED: begin
               if (pressed) begin
                  if (clicks < REPEAT_MAX) clicks++;
                  fired    = EV_REPEAT;
                  hold_cnt = '0;
                  st       = ST_REPEAT;
               end else if (hold_cnt > short_lim) begin
                  if (clicks == 4'd1) fired = EV_SINGLE;
                  else if (clicks == 4'd2) fired = EV_DOUBLE;
                  st = ST_IDLE;
               end
            end
            ST_REPEAT: begin
               if (!pressed) begin
                  fired = EV_UP;
                  if (hold_cnt < short_lim) begin
                     hold_cnt = '0;
                     st       = ST_RELEASED;
                  end else begin
                     st = ST_IDLE;
                  end
               end
            end
            ST_LONG_HOLD: begin
               if (pressed) fired = EV_LONG_HOLD;
               else st = ST_IDLE;
            end
            default: ;
         endcase

         if (fired != EV_NONE) last_ev = {1'b0, fired};
         word.fired   = fired;
         word.timeout = tmo;
         word.last    = last_ev;
         awaited.push_back(word);
      endfunction

      // Compare one received word with the oldest expectation.
      function void check_tick(logic [2:0] fired, logic tmo, logic [LAST_W-1:0] last);
         result_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: unexpected word: event %0d timeout %0d last %0d",
                     $time, fired, tmo, last);
            return;
         end
         want = awaited.pop_front();
         if (fired !== want.fired) begin
            failures++;
            $display("%0t: fired_event expected %0d, got %0d", $time, want.fired, fired);
         end
         if (tmo !== want.timeout) begin
            failures++;
            $display("%0t: idle_timeout expected %0d, got %0d", $time, want.timeout, tmo);
         end
         if (last !== want.last) begin
            failures++;
            $display("%0t: last_event expected %0d, got %0d", $time, want.last, last);
         end
      endfunction
   endclass

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_pin       = 1'b0;
   logic                   rsp_stall     = 1'b0;
   logic                   csr_write     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;
   wire                    req_stall;
   wire                    rsp_valid;
   wire  [2:0]             rsp_fired_event;
   wire                    rsp_idle_timeout;
   wire  [LAST_W-1:0]      rsp_last_event;

   click_scoreboard sb = new();
   bit              calm     = 1'b0;
   bit              squeeze  = 1'b0;
   bit              squeezed = 1'b0;
   int unsigned     hold_left = 0;

   button_click_event_detector DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin          (req_pin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fired_event  (rsp_fired_event),
      .rsp_idle_timeout (rsp_idle_timeout),
      .rsp_last_event   (rsp_last_event),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // Receiver: checks each accepted word, then decides the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_tick(rsp_fired_event, rsp_idle_timeout, rsp_last_event);
      if (squeeze && !squeezed) begin
         hold_left = 60;
         squeezed  = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 13);
      end
   end

   // Offer one tick, with an occasional gap first, and wait until it is taken.
   task automatic send_tick(input logic pin);
      while (!calm && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin   <= pin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(pin);
   endtask

   // Stop offering and wait until every expected word has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Write every register, plus one index past the list that must be ignored.
   task automatic apply_setting(input logic act, input logic [7:0] deb,
                                input logic [15:0] short_v, input logic [15:0] long_v,
                                input logic [15:0] idle_v);
      write_reg(CSR_ACTIVE_LEVEL, {15'd0, act});
      write_reg(CSR_DEBOUNCE_LIMIT, {8'd0, deb});
      write_reg(CSR_SHORT_LIMIT, short_v);
      write_reg(CSR_LONG_LIMIT, long_v);
      write_reg(CSR_IDLE_LIMIT, idle_v);
      write_reg(CSR_INDEX_W'(CSR_FIRST_UNUSED + $urandom_range(0, 2)),
                CSR_DATA_W'($urandom));
      csr_write <= 1'b0;
   endtask

   // Small limits, so that every event turns up within a few hundred ticks.
   task automatic random_setting();
      apply_setting(1'($urandom_range(0, 1)), 8'($urandom_range(1, 4)),
                    16'($urandom_range(3, 12)), 16'($urandom_range(5, 25)),
                    16'($urandom_range(10, 60)));
   endtask

   // Alternating press and release runs of random length with the odd glitch.
   task automatic click_burst(input int unsigned n_ticks);
      int unsigned sent;
      int unsigned len;
      logic        lvl;
      sent = 0;
      lvl  = sb.act_level;
      while (sent < n_ticks) begin
         case ($urandom_range(0, 9))
            0: len = 32'((lvl == sb.act_level) ? sb.long_lim : sb.idle_lim)
                     + 32'(sb.deb_lim) + $urandom_range(1, 8);
            1: len = $urandom_range(1, 3);
            default: len = $urandom_range(1, 32'(sb.short_lim) + 32'(sb.deb_lim) + 4);
         endcase
         for (int unsigned k = 0; k < len && sent < n_ticks; k++) begin
            if ($urandom_range(0, 19) == 0) send_tick(~lvl);
            else send_tick(lvl);
            sent++;
         end
         lvl = ~lvl;
      end
   endtask

   // Stimulus and end of run.
   initial begin
      logic act;
      logic far_level;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Press under the reset settings, then the directed click script.
      repeat (4) send_tick(1'b0);
      settle();
      apply_setting(1'b1, 8'd0, 16'd3, 16'd2, 16'd0);
      for (int i = 24; i >= 0; i--) send_tick(CLICK_SCRIPT[i]);
      settle();

      // Random clicking; the receiver holds off once early in the first burst.
      squeeze = 1'b1;
      repeat (2) begin
         random_setting();
         click_burst(60);
         settle();
      end

      // Widest debounce, zero short and long limits and the widest idle limit, with no idling on either side.
      // The pin is held away from the debounced level until it flips.
      calm = 1'b1;
      act  = 1'($urandom_range(0, 1));
      apply_setting(act, 8'd255, 16'd0, 16'd0, 16'd65535);
      far_level = ~sb.level;
      repeat (256) send_tick(far_level);
      repeat (8) send_tick(1'($urandom_range(0, 1)));
      settle();
      calm = 1'b0;

      // Saturate the repeat count with quick clicks.
      apply_setting(1'b1, 8'd1, 16'd65535, 16'd65535, 16'd65535);
      repeat (16) begin
         send_tick(1'b1);
         send_tick(1'b0);
      end
      repeat (3) send_tick(1'b0);
      settle();
      repeat (3) @(posedge clock);

      if (sb.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog.
   initial begin
      #12_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/bcd_pkg.sv
rtl/bcd_debounce.sv
rtl/bcd_fsm.sv
rtl/button_click_event_detector.sv
test/tb_button_click_event_detector.sv
